// File: src/wbau_pkg.sv
package wbau_pkg;

   localparam int unsigned ADDR_W = 12;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned PTR_W  = 8;
   localparam int unsigned LOG2_W = 3;

   // operation codes
   localparam logic [3:0] OP_SET_BASE = 4'd0;
   localparam logic [3:0] OP_ADDRESS  = 4'd1;
   localparam logic [3:0] OP_SHORT    = 4'd2;
   localparam logic [3:0] OP_ROTATE   = 4'd3;
   localparam logic [3:0] OP_SAVE     = 4'd4;
   localparam logic [3:0] OP_RESTORE  = 4'd5;
   localparam logic [3:0] OP_READ     = 4'd6;
   localparam logic [3:0] OP_WRITE    = 4'd7;
   localparam logic [3:0] OP_ADVANCE  = 4'd8;

   // address modes
   localparam logic [1:0] MODE_FLAT     = 2'd0;
   localparam logic [1:0] MODE_WINDOWED = 2'd1;
   localparam logic [1:0] MODE_ROTATING = 2'd2;

   // window register selectors
   localparam logic [2:0] SEL_POINTER    = 3'd0;
   localparam logic [2:0] SEL_CANSAVE    = 3'd1;
   localparam logic [2:0] SEL_CANRESTORE = 3'd2;
   localparam logic [2:0] SEL_OTHERWIN   = 3'd3;
   localparam logic [2:0] SEL_BASE       = 3'd4;
   localparam logic [2:0] SEL_SIZE       = 3'd5;
   localparam logic [2:0] SEL_ROTBASE    = 3'd6;
   localparam logic [2:0] SEL_ROTSIZE    = 3'd7;

   // error codes
   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_RESERVED  = 3'd1;
   localparam logic [2:0] ERR_ROT_ZERO  = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
   localparam logic [2:0] ERR_UNDERFLOW = 3'd4;
   localparam logic [2:0] ERR_UNKNOWN   = 3'd5;

   localparam logic [LOG2_W-1:0] WIN_LOG2_RESET = 3'd3;

   typedef struct packed {
      logic [3:0]        opcode;
      logic [1:0]        addr_mode;
      logic [27:0]       offset;
      logic [DATA_W-1:0] index_value;
      logic [4:0]        short_index;
      logic [2:0]        select;
      logic [DATA_W-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] bank_address;
      logic [DATA_W-1:0] read_value;
      logic [2:0]        error_code;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// File: src/windowed_bank_address_unit.sv
// Windowed bank address unit: address generator and window controller for a
// register bank. One operation beat comes in on req_* (valid/ready) and one
// result beat goes out on rsp_* (valid/ready): masked bank address, window
// register read value and error code.
// The user must write the window size code (csr_write_enable/csr_write_data)
// only while the unit is idle; the unit does not enforce this. It takes
// effect for the next operation. Except for rotating forms with a nonzero
// rotation size, a result is registered once the output register is free.
// Rotating forms with a nonzero rotation size run the 64-bit remainder unit,
// one quotient bit per cycle. No new beat is taken until a result is registered.
// The result sits in an output register: while the receiver stalls, the next
// beat is still accepted and computed, and it waits in the unit until the
// output register frees up; no window state changes until then.
// Reset (synchronous, active high) clears all window registers, sets the
// window size code to 3 and drops any pending result.
module windowed_bank_address_unit #(
   parameter int unsigned BANK_ENTRIES = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wbau_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wbau_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_write_data
);
   import wbau_pkg::*;

   // controller drives the datapath only through these
   cmd_type    cmd;
   status_type status;

   wbau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window registers, address forming, remainder unit and result register
   wbau_dpath #(
      .BANK_ENTRIES (BANK_ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule

// File: src/wbau_rem.sv
module wbau_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] remainder
);
   import wbau_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  count_ff, count_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [63:0] div_ff, div_in;
   logic [63:0] rem_ff, rem_in;

   logic [64:0] shifted;
   logic [64:0] diff;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   assign shifted = {rem_ff, dvd_ff[63]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = '0;
         dvd_in   = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = diff[64] ? shifted[63:0] : diff[63:0];
         dvd_in   = {dvd_ff[62:0], 1'b0};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) !(busy_ff && done_ff))
      else $error("remainder unit busy and done at once");
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && div_ff != 64'd0) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");
`endif

endmodule

// File: src/wbau_dpath.sv
module wbau_dpath #(
   parameter int unsigned BANK_ENTRIES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wbau_pkg::cmd_type    cmd,
   output wbau_pkg::status_type status,
   input  wbau_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wbau_pkg::rsp_type    rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_write_data
);
   import wbau_pkg::*;

   localparam logic [DATA_W-1:0] BASE_MASK = DATA_W'(BANK_ENTRIES - 1);
   localparam logic [ADDR_W-1:0] BANK_MASK = ADDR_W'(BANK_ENTRIES - 1);

   req_type           req_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [LOG2_W-1:0] log2_ff, log2_in;
   logic [DATA_W-1:0] base_ff, base_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [DATA_W-1:0] saves_ff, saves_in;
   logic [DATA_W-1:0] restores_ff, restores_in;
   logic [DATA_W-1:0] other_ff, other_in;
   logic [ADDR_W-1:0] rot_base_ff, rot_base_in;
   logic [DATA_W-1:0] rot_size_ff, rot_size_in;

   logic [DATA_W-1:0] sum;
   logic [DATA_W-1:0] win_size;
   logic [ADDR_W-1:0] win_mask;
   logic [ADDR_W-1:0] win_addr;
   logic              rot_op;
   logic              div_done;
   logic [DATA_W-1:0] remainder;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] rd;
   logic [2:0]        err;
   logic              out_free;

   wbau_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (sum),
      .divisor   (rot_size_ff),
      .done      (div_done),
      .remainder (remainder)
   );

   assign sum      = base_ff + req_ff.index_value + DATA_W'(req_ff.offset);
   assign win_size = DATA_W'(1) << log2_ff;
   assign win_mask = ADDR_W'((ADDR_W'(1) << log2_ff) - ADDR_W'(1));
   assign win_addr = ADDR_W'({4'd0, ptr_ff} << log2_ff) + (sum[ADDR_W-1:0] & win_mask);
   assign rot_op   = (req_ff.opcode == OP_ROTATE) ||
                     (req_ff.opcode == OP_ADDRESS && req_ff.addr_mode == MODE_ROTATING);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.need_div = rot_op && (rot_size_ff != '0);
   assign status.div_done = div_done;
   assign status.out_free = out_free;

   // result and window register update for the held operation
   always_comb begin
      base_in     = base_ff;
      ptr_in      = ptr_ff;
      saves_in    = saves_ff;
      restores_in = restores_ff;
      other_in    = other_ff;
      rot_base_in = rot_base_ff;
      rot_size_in = rot_size_ff;
      addr        = '0;
      rd          = '0;
      err         = ERR_OK;
      case (req_ff.opcode)
         OP_SET_BASE: begin
            base_in = req_ff.operand_value;
         end
         OP_ADDRESS, OP_ROTATE: begin
            if (rot_op) begin
               if (rot_size_ff == '0) begin
                  err = ERR_ROT_ZERO;
               end else begin
                  addr = rot_base_ff + remainder[ADDR_W-1:0];
               end
            end else begin
               case (req_ff.addr_mode)
                  MODE_FLAT:     addr = sum[ADDR_W-1:0];
                  MODE_WINDOWED: addr = win_addr;
                  default:       err  = ERR_RESERVED;
               endcase
            end
         end
         OP_SHORT: begin
            addr = base_ff[ADDR_W-1:0] + ADDR_W'(req_ff.short_index);
         end
         OP_SAVE: begin
            if (saves_ff == '0) begin
               err = ERR_OVERFLOW;
            end else begin
               ptr_in      = ptr_ff + PTR_W'(1);
               saves_in    = saves_ff - DATA_W'(1);
               restores_in = restores_ff + DATA_W'(1);
            end
         end
         OP_RESTORE: begin
            if (restores_ff == '0) begin
               err = ERR_UNDERFLOW;
            end else begin
               ptr_in      = ptr_ff - PTR_W'(1);
               saves_in    = saves_ff + DATA_W'(1);
               restores_in = restores_ff - DATA_W'(1);
            end
         end
         OP_READ: begin
            case (req_ff.select)
               SEL_POINTER:    rd = DATA_W'(ptr_ff);
               SEL_CANSAVE:    rd = saves_ff;
               SEL_CANRESTORE: rd = restores_ff;
               SEL_OTHERWIN:   rd = other_ff;
               SEL_BASE:       rd = base_ff;
               SEL_SIZE:       rd = DATA_W'(log2_ff);
               SEL_ROTBASE:    rd = DATA_W'(rot_base_ff);
               default:        rd = rot_size_ff;
            endcase
         end
         OP_WRITE: begin
            case (req_ff.select)
               SEL_POINTER:    ptr_in      = req_ff.operand_value[PTR_W-1:0];
               SEL_CANSAVE:    saves_in    = req_ff.operand_value;
               SEL_CANRESTORE: restores_in = req_ff.operand_value;
               SEL_OTHERWIN:   other_in    = req_ff.operand_value;
               SEL_BASE:       base_in     = req_ff.operand_value;
               SEL_ROTBASE:    rot_base_in = req_ff.operand_value[ADDR_W-1:0] & BANK_MASK;
               SEL_ROTSIZE:    rot_size_in = req_ff.operand_value;
               default:        ;
            endcase
         end
         OP_ADVANCE: begin
            base_in = (base_ff + win_size) & BASE_MASK;
         end
         default: begin
            err = ERR_UNKNOWN;
         end
      endcase
   end

   always_comb begin
      rsp_in.bank_address = (err == ERR_OK) ? (addr & BANK_MASK) : '0;
      rsp_in.read_value   = rd;
      rsp_in.error_code   = err;
      rsp_valid_in        = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      log2_in = csr_write_enable ? csr_write_data : log2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         log2_ff      <= WIN_LOG2_RESET;
         base_ff      <= '0;
         ptr_ff       <= '0;
         saves_ff     <= '0;
         restores_ff  <= '0;
         other_ff     <= '0;
         rot_base_ff  <= '0;
         rot_size_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         log2_ff      <= log2_in;
         if (cmd.commit) begin
            base_ff     <= base_in;
            ptr_ff      <= ptr_in;
            saves_ff    <= saves_in;
            restores_ff <= restores_in;
            other_ff    <= other_in;
            rot_base_ff <= rot_base_in;
            rot_size_ff <= rot_size_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over a beat not yet taken");
`endif

endmodule

// File: src/wbau_ctrl.sv
module wbau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wbau_pkg::status_type status,
   output wbau_pkg::cmd_type    cmd
);
   import wbau_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.need_div) begin
               state_in = ST_DIVIDE;
            end else if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.capture   = 1'b0;
      cmd.div_start = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.div_start = status.need_div;
            cmd.commit    = !status.need_div && status.out_free;
         end
         ST_DRAIN: begin
            cmd.commit = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.div_start, cmd.commit}))
      else $error("more than one datapath command at once");
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == ST_DIVIDE && !status.div_done))
      else $error("remainder start not followed by wait");
`endif

endmodule

// File: test/tb_top.sv
module tb_top;
   import wbau_pkg::*;

   localparam int unsigned BANK_ENTRIES = 4096;
   localparam logic [63:0] BANK_MASK    = 64'(BANK_ENTRIES - 1);
   localparam logic [63:0] ALL_ONES     = '1;
   localparam logic [27:0] OFFSET_ONES  = '1;
   // codes that the package leaves unnamed
   localparam logic [1:0]  MODE_RESERVED = 2'd3;
   localparam logic [3:0]  OP_UNUSED_LO  = 4'd9;
   localparam logic [3:0]  OP_UNUSED_HI  = 4'd15;
   localparam int          PHASES        = 8;
   localparam int          PHASE_BEATS   = 110;
   localparam int          CYCLE_LIMIT   = 500000;
   // give the tail a margin past the remainder run of a rotating form
   localparam int          DRAIN_CYCLES  = 100;

   typedef struct packed {
      req_type op;
      logic    known;
      rsp_type result;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic [2:0] csr_write_data = '0;

   // window state as the unit should hold it
   logic [2:0]  win_log2;
   logic [63:0] win_base;
   logic [7:0]  win_ptr;
   logic [63:0] saves_cnt;
   logic [63:0] restores_cnt;
   logic [63:0] other_win;
   logic [11:0] rot_base;
   logic [63:0] rot_size;

   rsp_type pending_results[$];
   row_type directed_rows[$];

   int  cycles = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   int  rotating_beats = 0;
   int  mismatches = 0;
   int  codes_visited = 1;
   bit  sender_gaps = 1'b0;
   bit  receiver_stalls = 1'b0;

   windowed_bank_address_unit #(
      .BANK_ENTRIES(BANK_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop in case a beat never comes
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Advance the window state by one operation and return the result beat
   // that it should produce.
   function automatic rsp_type apply_operation(input req_type r);
      rsp_type     res;
      logic [63:0] wsize;
      logic [63:0] sum;
      logic [63:0] addr;
      logic [1:0]  mode;
      logic [2:0]  err;
      res   = '0;
      err   = ERR_OK;
      addr  = '0;
      wsize = 64'd1 << win_log2;
      sum   = win_base + r.index_value + {36'd0, r.offset};
      case (r.opcode)
         OP_SET_BASE: win_base = r.operand_value;
         OP_ADDRESS, OP_ROTATE: begin
            mode = (r.opcode == OP_ROTATE) ? MODE_ROTATING : r.addr_mode;
            case (mode)
               MODE_FLAT:     addr = sum;
               MODE_WINDOWED: addr = {56'd0, win_ptr} * wsize + (sum & (wsize - 64'd1));
               MODE_ROTATING: begin
                  if (rot_size == '0) err = ERR_ROT_ZERO;
                  else addr = {52'd0, rot_base} + sum % rot_size;
               end
               default: err = ERR_RESERVED;
            endcase
         end
         OP_SHORT: addr = win_base + {59'd0, r.short_index};
         OP_SAVE: begin
            if (saves_cnt == '0) begin
               err = ERR_OVERFLOW;
            end else begin
               win_ptr      = win_ptr + 8'd1;
               saves_cnt    = saves_cnt - 64'd1;
               restores_cnt = restores_cnt + 64'd1;
            end
         end
         OP_RESTORE: begin
            if (restores_cnt == '0) begin
               err = ERR_UNDERFLOW;
            end else begin
               win_ptr      = win_ptr - 8'd1;
               saves_cnt    = saves_cnt + 64'd1;
               restores_cnt = restores_cnt - 64'd1;
            end
         end
         OP_READ: begin
            case (r.select)
               SEL_POINTER:    res.read_value = {56'd0, win_ptr};
               SEL_CANSAVE:    res.read_value = saves_cnt;
               SEL_CANRESTORE: res.read_value = restores_cnt;
               SEL_OTHERWIN:   res.read_value = other_win;
               SEL_BASE:       res.read_value = win_base;
               SEL_SIZE:       res.read_value = {61'd0, win_log2};
               SEL_ROTBASE:    res.read_value = {52'd0, rot_base};
               default:        res.read_value = rot_size;
            endcase
         end
         OP_WRITE: begin
            case (r.select)
               SEL_POINTER:    win_ptr = r.operand_value[7:0];
               SEL_CANSAVE:    saves_cnt = r.operand_value;
               SEL_CANRESTORE: restores_cnt = r.operand_value;
               SEL_OTHERWIN:   other_win = r.operand_value;
               SEL_BASE:       win_base = r.operand_value;
               SEL_SIZE:       ; // size code comes only from the csr port
               SEL_ROTBASE:    rot_base = r.operand_value[11:0] & BANK_MASK[11:0];
               default:        rot_size = r.operand_value;
            endcase
         end
         OP_ADVANCE: win_base = (win_base + wsize) & BANK_MASK;
         default: err = ERR_UNKNOWN;
      endcase
      if (err != ERR_OK) addr = '0;
      addr = addr & BANK_MASK;
      res.bank_address = addr[ADDR_W-1:0];
      res.error_code   = err;
      return res;
   endfunction

   function automatic req_type op_word(input logic [3:0] opcode, input logic [1:0] mode,
                                       input logic [27:0] offset, input logic [63:0] index,
                                       input logic [4:0] short_index, input logic [2:0] sel,
                                       input logic [63:0] operand);
      req_type r;
      r.opcode        = opcode;
      r.addr_mode     = mode;
      r.offset        = offset;
      r.index_value   = index;
      r.short_index   = short_index;
      r.select        = sel;
      r.operand_value = operand;
      return r;
   endfunction

   // Bias 64-bit values toward the edges and toward small counts.
   function automatic logic [63:0] wide_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return 64'($urandom_range(0, 4095));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_op();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)       r.opcode = OP_SET_BASE;
      else if (pick < 30) r.opcode = OP_ADDRESS;
      else if (pick < 38) r.opcode = OP_SHORT;
      else if (pick < 48) r.opcode = OP_ROTATE;
      else if (pick < 58) r.opcode = OP_SAVE;
      else if (pick < 68) r.opcode = OP_RESTORE;
      else if (pick < 78) r.opcode = OP_READ;
      else if (pick < 92) r.opcode = OP_WRITE;
      else if (pick < 96) r.opcode = OP_ADVANCE;
      else r.opcode = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      r.addr_mode   = 2'($urandom_range(0, 3));
      r.offset      = ($urandom_range(0, 9) == 0) ? OFFSET_ONES : 28'($urandom);
      r.index_value = wide_value();
      r.short_index = 5'($urandom);
      r.select      = 3'($urandom);
      // keep counters and rotation sizes small half the time so that saves,
      // restores and the remainder see both of their outcomes
      if (r.opcode == OP_WRITE && $urandom_range(0, 1) == 0)
         r.operand_value = 64'($urandom_range(0, 300));
      else
         r.operand_value = wide_value();
      return r;
   endfunction

   task automatic row_open(input req_type r);
      directed_rows.push_back({r, 1'b0, rsp_type'('0)});
   endtask

   task automatic row_known(input req_type r, input logic [11:0] addr,
                            input logic [63:0] value, input logic [2:0] err);
      rsp_type res;
      res.bank_address = addr;
      res.read_value   = value;
      res.error_code   = err;
      directed_rows.push_back({r, 1'b1, res});
   endtask

   // Hold the beat until it is taken, then queue what it should produce.
   task automatic send_beat(input req_type r, input logic known, input rsp_type known_result);
      rsp_type res;
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = apply_operation(r);
      if (known) res = known_result;
      pending_results.push_back(res);
      beats_sent++;
      if (r.opcode == OP_ROTATE || (r.opcode == OP_ADDRESS && r.addr_mode == MODE_ROTATING))
         rotating_beats++;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every result is back, so the unit is idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_size_code(input logic [2:0] code);
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(posedge clock);
      win_log2 = code;
      csr_write_enable <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s at result %0d: addr %h/%h value %h/%h err %0d/%0d (exp/got)", what,
                  beats_checked, want.bank_address, got.bank_address, want.read_value,
                  got.read_value, want.error_code, got.error_code);
   endtask

   // Result side: pop the oldest expectation for each beat the unit hands over.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected beat", rsp_type'('0), rsp_payload);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.bank_address !== want.bank_address ||
                rsp_payload.read_value !== want.read_value ||
                rsp_payload.error_code !== want.error_code)
               report_mismatch("mismatch", want, rsp_payload);
         end
         beats_checked++;
      end
   end

   // Receiver: drop ready in random bursts while stalls are enabled.
   initial begin
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      logic [2:0] code;
      win_log2     = WIN_LOG2_RESET;
      win_base     = '0;
      win_ptr      = '0;
      saves_cnt    = '0;
      restores_cnt = '0;
      other_win    = '0;
      rot_base     = '0;
      rot_size     = '0;

      // Directed table: state right after reset, size code 3.
      row_known(op_word(OP_READ, MODE_FLAT, '0, '0, '0, SEL_SIZE, '0), '0, 64'd3, ERR_OK);
      row_known(op_word(OP_READ, MODE_FLAT, '0, '0, '0, SEL_ROTSIZE, '0), '0, '0, ERR_OK);
      // save and restore with empty counters
      row_known(op_word(OP_SAVE, MODE_FLAT, '0, '0, '0, '0, '0), '0, '0, ERR_OVERFLOW);
      row_known(op_word(OP_RESTORE, MODE_FLAT, '0, '0, '0, '0, '0), '0, '0, ERR_UNDERFLOW);
      row_known(op_word(OP_ADDRESS, MODE_RESERVED, OFFSET_ONES, ALL_ONES, '1, '1, ALL_ONES),
                '0, '0, ERR_RESERVED);
      // rotating forms with no rotation size set
      row_known(op_word(OP_ADDRESS, MODE_ROTATING, OFFSET_ONES, ALL_ONES, '0, '0, '0),
                '0, '0, ERR_ROT_ZERO);
      row_known(op_word(OP_ROTATE, MODE_FLAT, '0, 64'd5, '0, '0, '0), '0, '0, ERR_ROT_ZERO);
      row_known(op_word(OP_UNUSED_LO, MODE_FLAT, '0, '0, '0, '0, ALL_ONES), '0, '0, ERR_UNKNOWN);
      row_known(op_word(OP_UNUSED_HI, MODE_RESERVED, OFFSET_ONES, ALL_ONES, '1, '1, ALL_ONES),
                '0, '0, ERR_UNKNOWN);
      // flat sum wraps at 64 bits: -1 + 0x0FFFFFFF
      row_known(op_word(OP_ADDRESS, MODE_FLAT, OFFSET_ONES, ALL_ONES, '0, '0, '0),
                12'hFFE, '0, ERR_OK);
      row_known(op_word(OP_SHORT, MODE_FLAT, '0, '0, '1, '0, '0), 12'd31, '0, ERR_OK);
      // writes to the size selector are dropped
      row_open(op_word(OP_WRITE, MODE_FLAT, '0, '0, '0, SEL_SIZE, ALL_ONES));
      row_known(op_word(OP_READ, MODE_FLAT, '0, '0, '0, SEL_SIZE, '0), '0, 64'd3, ERR_OK);
      // rotation base is clipped to the bank
      row_open(op_word(OP_WRITE, MODE_FLAT, '0, '0, '0, SEL_ROTBASE, ALL_ONES));
      row_known(op_word(OP_READ, MODE_FLAT, '0, '0, '0, SEL_ROTBASE, '0), '0, 64'hFFF, ERR_OK);
      row_open(op_word(OP_WRITE, MODE_FLAT, '0, '0, '0, SEL_ROTSIZE, ALL_ONES));
      row_open(op_word(OP_ROTATE, MODE_FLAT, OFFSET_ONES, ALL_ONES, '0, '0, '0));
      // counters wrap, pointer steps below zero
      row_open(op_word(OP_WRITE, MODE_FLAT, '0, '0, '0, SEL_CANRESTORE, ALL_ONES));
      row_open(op_word(OP_WRITE, MODE_FLAT, '0, '0, '0, SEL_CANSAVE, ALL_ONES));
      row_open(op_word(OP_RESTORE, MODE_FLAT, '0, '0, '0, '0, '0));
      row_known(op_word(OP_READ, MODE_FLAT, '0, '0, '0, SEL_POINTER, '0), '0, 64'hFF, ERR_OK);
      row_open(op_word(OP_SAVE, MODE_FLAT, '0, '0, '0, '0, '0));
      // advance from the top of the address space lands on 7
      row_open(op_word(OP_SET_BASE, MODE_FLAT, '0, '0, '0, '0, ALL_ONES));
      row_known(op_word(OP_ADVANCE, MODE_FLAT, '0, '0, '0, '0, '0), '0, '0, ERR_OK);
      row_known(op_word(OP_READ, MODE_FLAT, '0, '0, '0, SEL_BASE, '0), '0, 64'd7, ERR_OK);
      row_open(op_word(OP_WRITE, MODE_FLAT, '0, '0, '0, SEL_POINTER, ALL_ONES));
      row_open(op_word(OP_ADDRESS, MODE_WINDOWED, OFFSET_ONES, ALL_ONES, '0, '0, '0));
      row_open(op_word(OP_WRITE, MODE_FLAT, '0, '0, '0, SEL_OTHERWIN, ALL_ONES));
      row_open(op_word(OP_READ, MODE_FLAT, '0, '0, '0, SEL_OTHERWIN, '0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_beat(directed_rows[i].op, directed_rows[i].known, directed_rows[i].result);

      // Random phases, one size code each; the extremes come first and the
      // last phase runs with no idling on either side.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         code = (phase == 0) ? 3'd0 : (phase == 1) ? 3'd7 : 3'($urandom_range(0, 7));
         write_size_code(code);
         codes_visited++;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (phase == PHASES - 1) begin
               sender_gaps     = 1'b0;
               receiver_stalls = 1'b0;
            end else if (n % 40 == 0) begin
               sender_gaps     = ($urandom_range(0, 2) != 0);
               receiver_stalls = ($urandom_range(0, 2) != 0);
            end
            send_beat(random_op(), 1'b0, rsp_type'('0));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d operations (%0d rotating) across %0d size code settings.",
               beats_sent, rotating_beats, codes_visited);
      $display("Checked %0d result beats, %0d mismatches.", beats_checked, mismatches);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
